// ----- design/brpd_pkg.sv -----
package brpd_pkg;

  localparam int DIM_W      = 13;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int ADDR_W     = 24;
  localparam int RGB_W      = 24;
  localparam int PAL_IDX_W  = 8;
  localparam int PALETTE_ENTRIES = 256;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // Pixel modes.
  localparam logic [MODE_W-1:0] MODE_1BPP = 3'd0;
  localparam logic [MODE_W-1:0] MODE_4BPP = 3'd1;
  localparam logic [MODE_W-1:0] MODE_8BPP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BGR  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BGRA = 3'd4;

  // Input actions.
  localparam logic ACT_PALETTE = 1'b0;
  localparam logic ACT_PIXEL   = 1'b1;

  // How the back end turns a queued byte into pixels.
  localparam logic [1:0] KIND_BIT    = 2'd0;
  localparam logic [1:0] KIND_NIBBLE = 2'd1;
  localparam logic [1:0] KIND_INDEX  = 2'd2;
  localparam logic [1:0] KIND_DIRECT = 2'd3;

  typedef struct packed {
    logic                 is_palette;
    logic [1:0]           kind;
    logic [3:0]           count;
    logic [PAL_IDX_W-1:0] data;
    logic [RGB_W-1:0]     color;
    logic [ADDR_W-1:0]    address;
    logic                 eoi;
  } run_t;

endpackage

// ----- design/bmp_row_pixel_decoder.sv -----
// Channel   Direction  Handshake              Payload
// config    in         cfg_write              cfg_index, cfg_data
// input     in         in_valid / in_ready    action, data_byte, palette_*
// pixels    out        out_valid / out_ready  pixel_rgb, pixel_address, flags
//
// One input item is accepted per cycle while the four-entry run queue has room.
// The pixel side emits one pixel per cycle while out_ready is high, so a 1 bpp
// byte holds the back end for up to eight pixels and a 4 bpp byte for two; the
// queue then fills and in_ready drops. Reset restores the register defaults;
// the palette reads as zero until written.
module bmp_row_pixel_decoder #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [brpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brpd_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           action,
  input  logic [7:0]                     data_byte,
  input  logic [7:0]                     palette_index,
  input  logic [7:0]                     palette_red,
  input  logic [7:0]                     palette_green,
  input  logic [7:0]                     palette_blue,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [brpd_pkg::RGB_W-1:0]     pixel_rgb,
  output logic [brpd_pkg::ADDR_W-1:0]    pixel_address,
  output logic                           last_of_run,
  output logic                           end_of_image
);
  import brpd_pkg::*;

  run_t push_entry;
  run_t head;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;

  brpd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .data_byte     (data_byte),
    .palette_index (palette_index),
    .palette_red   (palette_red),
    .palette_green (palette_green),
    .palette_blue  (palette_blue),
    .q_full        (q_full),
    .push          (push),
    .entry         (push_entry)
  );

  brpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  brpd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (!q_empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_rgb     (pixel_rgb),
    .pixel_address (pixel_address),
    .last_of_run   (last_of_run),
    .end_of_image  (end_of_image)
  );

endmodule

// ----- design/brpd_front.sv -----
module brpd_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [brpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brpd_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           action,
  input  logic [7:0]                     data_byte,
  input  logic [7:0]                     palette_index,
  input  logic [7:0]                     palette_red,
  input  logic [7:0]                     palette_green,
  input  logic [7:0]                     palette_blue,
  input  logic                           q_full,
  output logic                           push,
  output brpd_pkg::run_t                 entry
);
  import brpd_pkg::*;

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HEW = $clog2(MAX_HEIGHT + 1);
  localparam int HW  = $clog2(MAX_HEIGHT);
  localparam int RBW = $clog2(4 * MAX_WIDTH + 4);

  function automatic logic [WW-1:0] clamp_w(input logic [DIM_W-1:0] v);
    if (v == '0) return WW'(1);
    else if (32'(v) > MAX_WIDTH) return WW'(MAX_WIDTH);
    else return WW'(v);
  endfunction

  function automatic logic [HEW-1:0] clamp_h(input logic [DIM_W-1:0] v);
    if (v == '0) return HEW'(1);
    else if (32'(v) > MAX_HEIGHT) return HEW'(MAX_HEIGHT);
    else return HEW'(v);
  endfunction

  logic [MODE_W-1:0] pixel_mode, mode_next;
  logic [DIM_W-1:0]  image_width, width_next;
  logic [DIM_W-1:0]  image_height, height_next;
  logic [WW-1:0]     column_count;
  logic [HW-1:0]     row_count;
  logic [RBW-1:0]    row_byte_count;
  logic [1:0]        byte_phase, phase_next;
  logic [7:0]        held_blue, blue_next;
  logic [7:0]        held_green, green_next;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] image_base;
  logic [ADDR_W-1:0] base_next;
  logic [WW+HEW-1:0] base_prod;

  logic              restart;
  logic [WW-1:0]     w_eff;
  logic [HEW-1:0]    h_eff;
  logic [WW-1:0]     cols_left;
  logic [WW-1:0]     col_sum;
  logic              col_open;
  logic              active;
  logic              mode_ok;
  logic              row_last;
  logic              row_end;
  logic              byte_accept;
  logic [3:0]        cnt;
  logic [1:0]        kind;
  logic [RBW-1:0]    w_ext;
  logic [RBW-1:0]    raw_len;
  logic [RBW-1:0]    row_len;

  // Configuration writes; any write to a listed register restarts the image.
  always_comb begin
    mode_next   = pixel_mode;
    width_next  = image_width;
    height_next = image_height;
    restart     = 1'b0;
    if (cfg_write) begin
      unique case (cfg_index)
        REG_PIXEL_MODE: begin
          mode_next = cfg_data[MODE_W-1:0];
          restart   = 1'b1;
        end
        REG_IMAGE_WIDTH: begin
          width_next = cfg_data;
          restart    = 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          height_next = cfg_data;
          restart     = 1'b1;
        end
        default: ;
      endcase
    end
    base_prod = clamp_w(width_next) * (clamp_h(height_next) - HEW'(1));
    base_next = ADDR_W'(base_prod);
  end

  always_comb begin
    w_eff     = clamp_w(image_width);
    h_eff     = clamp_h(image_height);
    cols_left = w_eff - column_count;
    col_open  = column_count < w_eff;
    active    = col_open || (byte_phase != 2'd0);
    mode_ok   = pixel_mode <= MODE_BGRA;
    row_last  = HEW'(row_count) == (h_eff - HEW'(1));

    phase_next = byte_phase;
    blue_next  = held_blue;
    green_next = held_green;
    cnt        = 4'd0;
    kind       = KIND_INDEX;
    unique case (pixel_mode)
      MODE_1BPP: begin
        kind = KIND_BIT;
        if (active) cnt = (cols_left > WW'(8)) ? 4'd8 : 4'(cols_left);
      end
      MODE_4BPP: begin
        kind = KIND_NIBBLE;
        if (active) cnt = (cols_left > WW'(2)) ? 4'd2 : 4'(cols_left);
      end
      MODE_8BPP: begin
        kind = KIND_INDEX;
        if (active) cnt = 4'd1;
      end
      default: begin
        kind = KIND_DIRECT;
        if (active) begin
          unique case (byte_phase)
            2'd0: begin
              blue_next  = data_byte;
              phase_next = 2'd1;
            end
            2'd1: begin
              green_next = data_byte;
              phase_next = 2'd2;
            end
            2'd2: begin
              if (col_open) cnt = 4'd1;
              phase_next = (pixel_mode == MODE_BGRA) ? 2'd3 : 2'd0;
            end
            default: phase_next = 2'd0;
          endcase
        end
      end
    endcase

    // Row length in bytes, rounded up to a multiple of four.
    w_ext = RBW'(w_eff);
    unique case (pixel_mode)
      MODE_1BPP: raw_len = (w_ext + RBW'(7)) >> 3;
      MODE_4BPP: raw_len = (w_ext + RBW'(1)) >> 1;
      MODE_8BPP: raw_len = w_ext;
      MODE_BGR:  raw_len = (w_ext << 1) + w_ext;
      default:   raw_len = w_ext << 2;
    endcase
    row_len = (raw_len + RBW'(3)) & ~RBW'(3);
    row_end = (row_byte_count + RBW'(1)) >= row_len;
    col_sum = column_count + WW'(cnt);
  end

  assign in_ready    = !q_full;
  assign byte_accept = in_valid && in_ready && (action == ACT_PIXEL) && mode_ok;
  assign push        = in_valid && in_ready &&
                       ((action == ACT_PALETTE) || (mode_ok && (cnt != 4'd0)));

  always_comb begin
    entry            = '0;
    entry.is_palette = action == ACT_PALETTE;
    entry.kind       = kind;
    entry.count      = cnt;
    entry.address    = row_base + ADDR_W'(column_count);
    entry.eoi        = row_last && (col_sum == w_eff) && (cnt != 4'd0);
    if (action == ACT_PALETTE) begin
      entry.data  = palette_index;
      entry.color = {palette_blue, palette_green, palette_red};
    end else begin
      entry.data  = data_byte;
      entry.color = {held_blue, held_green, data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode     <= MODE_8BPP;
      image_width    <= DIM_W'(1);
      image_height   <= DIM_W'(1);
      column_count   <= '0;
      row_count      <= '0;
      row_byte_count <= '0;
      byte_phase     <= 2'd0;
      held_blue      <= 8'd0;
      held_green     <= 8'd0;
      row_base       <= '0;
      image_base     <= '0;
    end else if (restart) begin
      pixel_mode     <= mode_next;
      image_width    <= width_next;
      image_height   <= height_next;
      column_count   <= '0;
      row_count      <= '0;
      row_byte_count <= '0;
      byte_phase     <= 2'd0;
      held_blue      <= 8'd0;
      held_green     <= 8'd0;
      row_base       <= base_next;
      image_base     <= base_next;
    end else if (byte_accept) begin
      held_blue  <= blue_next;
      held_green <= green_next;
      if (row_end) begin
        column_count   <= '0;
        row_byte_count <= '0;
        byte_phase     <= 2'd0;
        if (row_last) begin
          row_count <= '0;
          row_base  <= image_base;
        end else begin
          row_count <= row_count + HW'(1);
          row_base  <= row_base - ADDR_W'(w_eff);
        end
      end else begin
        column_count   <= col_sum;
        row_byte_count <= row_byte_count + RBW'(1);
        byte_phase     <= phase_next;
      end
    end
  end

  a_pixel_run_nonempty: assert property (@(posedge clk) disable iff (rst)
    push && !entry.is_palette |-> entry.count != 4'd0)
    else $error("pixel run queued without pixels");

endmodule

// ----- design/brpd_queue.sv -----
module brpd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  brpd_pkg::run_t push_entry,
  input  logic           pop,
  output brpd_pkg::run_t head,
  output logic           empty,
  output logic           full
);
  import brpd_pkg::*;

  run_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign head  = slots[rd_ptr];
  assign empty = count == '0;
  assign full  = count == (QPTR_W + 1)'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      unique case ({push, pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: ;
      endcase
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("queue read while empty");

endmodule

// ----- design/brpd_back.sv -----
module brpd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  brpd_pkg::run_t              head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [brpd_pkg::RGB_W-1:0]  pixel_rgb,
  output logic [brpd_pkg::ADDR_W-1:0] pixel_address,
  output logic                        last_of_run,
  output logic                        end_of_image
);
  import brpd_pkg::*;

  logic [RGB_W-1:0]     palette_mem [PALETTE_ENTRIES];
  logic                 palette_valid [PALETTE_ENTRIES];
  logic [RGB_W-1:0]     mem_q;
  logic                 sel_valid;
  logic                 direct_q;
  logic [RGB_W-1:0]     color_q;
  logic [ADDR_W-1:0]    addr_q;
  logic                 last_q;
  logic                 eoi_q;
  logic [2:0]           k;
  logic [PAL_IDX_W-1:0] rd_idx;
  logic                 last;
  logic                 load;
  logic                 pal_write;

  // Pixel k of the current byte picks its palette index, most significant first.
  always_comb begin
    unique case (head.kind)
      KIND_BIT:    rd_idx = {7'd0, head.data[3'd7 - k]};
      KIND_NIBBLE: rd_idx = (k == 3'd0) ? {4'd0, head.data[7:4]} : {4'd0, head.data[3:0]};
      KIND_INDEX:  rd_idx = head.data;
      default:     rd_idx = head.data;
    endcase
  end

  assign last      = ({1'b0, k} + 4'd1) == head.count;
  assign pal_write = q_valid && head.is_palette;
  assign load      = q_valid && !head.is_palette && (!out_valid || out_ready);
  assign pop       = pal_write || (load && last);

  always_ff @(posedge clk) begin
    if (pal_write) palette_mem[head.data] <= head.color;
    if (load) mem_q <= palette_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sel_valid <= palette_valid[rd_idx];
      direct_q  <= head.kind == KIND_DIRECT;
      color_q   <= head.color;
      addr_q    <= head.address + ADDR_W'(k);
      last_q    <= last;
      eoi_q     <= head.eoi && last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      k         <= 3'd0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) palette_valid[i] <= 1'b0;
    end else begin
      if (pal_write) palette_valid[head.data] <= 1'b1;
      if (load) begin
        out_valid <= 1'b1;
        k         <= last ? 3'd0 : k + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Entries never written read as black.
  assign pixel_rgb     = direct_q ? color_q : (sel_valid ? mem_q : '0);
  assign pixel_address = addr_q;
  assign last_of_run   = last_q;
  assign end_of_image  = eoi_q;

  a_k_within_run: assert property (@(posedge clk) disable iff (rst)
    q_valid && !head.is_palette |-> ({1'b0, k} < head.count))
    else $error("pixel counter ran past its run");

  a_eoi_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_image |-> last_of_run)
    else $error("end of image on a pixel that does not close its run");

endmodule
